/* hdl/iscbf_pkg.sv */
// ---------------------------------------------------------------------------
// IPv4 source counter / blocklist filter package
// Shared constants and types for the filter top level and its LRU tables.
// ---------------------------------------------------------------------------
`default_nettype none

package iscbf_pkg;

    // Default number of entries in each LRU table.
    localparam int TABLE_ENTRIES_DEF = 16;

    // Shortest frame that holds an Ethernet header and a minimal IPv4 header.
    localparam logic [15:0] MIN_IPV4_FRAME = 16'd34;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    // Item kinds.
    localparam logic KIND_PACKET    = 1'b0;
    localparam logic KIND_BLOCK_ADD = 1'b1;

    // Request presented to an LRU table for the transaction in flight.
    typedef struct packed {
        logic        access;          // look the key up and refresh recency on a hit
        logic        insert_on_miss;  // on a miss, insert the key as most recent
        logic [31:0] key;
    } lru_req_t;

endpackage

`default_nettype wire

/* hdl/ipv4_source_counter_blocklist_filter_top.sv */
// ---------------------------------------------------------------------------
// IPv4 source counter / blocklist filter top level
// Counts IPv4 frames per source address and drops frames from blocked sources.
// ---------------------------------------------------------------------------
// The block takes one transaction on every clock cycle: busy is never raised,
// so start may be held high continuously. A transaction is either a packet
// header summary (kind 0) or a request to add an address to the blocklist
// (kind 1). Every transaction yields exactly one result, shown on verdict,
// counted and packet_count for one cycle while done is high; the result of a
// transaction passes through the input register and then the result register,
// and results come out in the order the transactions went in.
// The receiver cannot stall the block, so it must take each result in the
// cycle in which done is high. Each transaction is first held in the input
// register; then both LRU tables are searched and updated in parallel and the
// result register is loaded. Packets shorter than 34 bytes or with an
// ethertype other than IPv4 pass with counted low and a count of zero.
// Valid IPv4 packets have their source counted in a TABLE_ENTRIES-entry table
// with true LRU replacement (counts wrap at 2^32) and are dropped when the
// source is on the blocklist, itself a TABLE_ENTRIES-entry LRU table.
// ---------------------------------------------------------------------------
`default_nettype none

module ipv4_source_counter_blocklist_filter_top #(
    parameter int TABLE_ENTRIES = iscbf_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic [15:0] frame_length,
    input  wire logic [15:0] ether_type,
    input  wire logic [31:0] source_address,
    output logic             done,
    output logic             verdict,
    output logic             counted,
    output logic [31:0]      packet_count
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    // Input register.
    logic        in_valid_reg;
    logic        kind_reg;
    logic [15:0] frame_length_reg;
    logic [15:0] ether_type_reg;
    logic [31:0] source_address_reg;

    // Result register.
    logic        done_reg;
    logic        verdict_reg;
    logic        counted_reg;
    logic [31:0] packet_count_reg;
    logic        verdict_next;
    logic        counted_next;
    logic [31:0] packet_count_next;

    // Per-slot counts of the source counter table.
    logic [31:0] count_reg [TABLE_ENTRIES];

    logic                is_packet;
    logic                ipv4_ok;
    iscbf_pkg::lru_req_t cnt_req;
    iscbf_pkg::lru_req_t blk_req;
    logic                cnt_hit;
    logic [IW-1:0]       cnt_slot;
    logic                blk_hit;
    logic [IW-1:0]       blk_slot;
    logic [31:0]         new_count;

    // The tables take the whole update for each transaction without stalling,
    // so the block is always ready.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg           <= kind;
            frame_length_reg   <= frame_length;
            ether_type_reg     <= ether_type;
            source_address_reg <= source_address;
        end
    end

    // A packet is counted only when the frame holds an Ethernet header plus a
    // minimal IPv4 header and the ethertype says IPv4.
    assign is_packet = (kind_reg == iscbf_pkg::KIND_PACKET);
    assign ipv4_ok   = is_packet
                       && (frame_length_reg >= iscbf_pkg::MIN_IPV4_FRAME)
                       && (ether_type_reg == iscbf_pkg::ETHERTYPE_IPV4);

    always_comb
    begin
        cnt_req.access         = in_valid_reg && ipv4_ok;
        cnt_req.insert_on_miss = 1'b1;
        cnt_req.key            = source_address_reg;

        // Counted packets look up the blocklist; add requests insert into it.
        blk_req.access         = in_valid_reg && (ipv4_ok || !is_packet);
        blk_req.insert_on_miss = !is_packet;
        blk_req.key            = source_address_reg;
    end

    iscbf_lru_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_cnt_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cnt_req),
        .hit   (cnt_hit),
        .slot  (cnt_slot)
    );

    iscbf_lru_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_blk_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (blk_req),
        .hit   (blk_hit),
        .slot  (blk_slot)
    );

    // A hit adds one with 32-bit wrap; a new source starts at one.
    assign new_count = cnt_hit ? (count_reg[cnt_slot] + 32'd1) : 32'd1;

    always_ff @(posedge clk)
    begin
        if (cnt_req.access)
        begin
            count_reg[cnt_slot] <= new_count;
        end
    end

    always_comb
    begin
        verdict_next      = ipv4_ok && blk_hit;
        counted_next      = ipv4_ok;
        packet_count_next = ipv4_ok ? new_count : 32'd0;
    end

    always_ff @(posedge clk)
    begin
        verdict_reg      <= verdict_next;
        counted_reg      <= counted_next;
        packet_count_reg <= packet_count_next;
    end

    assign done         = done_reg;
    assign verdict      = verdict_reg;
    assign counted      = counted_reg;
    assign packet_count = packet_count_reg;

    // Every accepted transaction produces its result through the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("filter: result missing two cycles after a transaction");

    // Only counted packets can be dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && verdict) |-> counted)
        else $error("filter: drop verdict on an uncounted transaction");

    // An uncounted transaction reports a count of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !counted) |-> (packet_count == 32'd0))
        else $error("filter: nonzero count on an uncounted transaction");

    // A counted packet whose source is on the blocklist is dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (blk_req.access && !blk_req.insert_on_miss && blk_hit) |=> done && verdict)
        else $error("filter: blocklist hit did not drop the packet");

    // The slots chosen by both tables always lie inside the tables.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_req.access || blk_req.access)
        |-> ((int'(cnt_slot) < TABLE_ENTRIES) && (int'(blk_slot) < TABLE_ENTRIES)))
        else $error("filter: table slot out of range");

endmodule

`default_nettype wire

/* hdl/iscbf_lru_table.sv */
// ---------------------------------------------------------------------------
// IPv4 source counter / blocklist filter: LRU table
// Fully associative key table with true LRU ages; lookup is combinational, keys and ages are registered.
// ---------------------------------------------------------------------------
`default_nettype none

module iscbf_lru_table #(
    parameter int ENTRIES = iscbf_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire iscbf_pkg::lru_req_t          req,
    output logic                              hit,
    output logic [$clog2(ENTRIES)-1:0]        slot
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] OLDEST_AGE = AW'(ENTRIES - 1);

    logic [31:0]   key_reg   [ENTRIES];
    logic [AW-1:0] age_reg   [ENTRIES];
    logic [AW-1:0] age_next  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;

    logic [ENTRIES-1:0] match;
    logic [AW-1:0]      hit_idx;
    logic [AW-1:0]      free_idx;
    logic [AW-1:0]      victim_idx;
    logic               any_free;
    logic [AW-1:0]      hit_age;
    logic               do_update;
    logic               inserting;

    // Lookup, free slot search and victim selection.
    always_comb
    begin
        hit_idx    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == req.key);
            if (match[i])
            begin
                hit_idx = hit_idx | AW'(i);
            end
            // When the table is full the ages are distinct, so exactly one
            // entry carries the oldest age.
            if (age_reg[i] == OLDEST_AGE)
            begin
                victim_idx = victim_idx | AW'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = AW'(i);
            end
        end
        any_free = ~&valid_reg;
        hit      = |match;
        hit_age  = age_reg[hit_idx];
        slot     = hit ? hit_idx : (any_free ? free_idx : victim_idx);
    end

    assign inserting = !hit && req.insert_on_miss;
    assign do_update = req.access && (hit || req.insert_on_miss);

    // Recency update: the touched slot becomes age zero, younger entries age
    // by one. An insert ages every other valid entry.
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
            if (do_update)
            begin
                if (slot == AW'(i))
                begin
                    age_next[i]   = '0;
                    valid_next[i] = 1'b1;
                end
                else if (valid_reg[i] && (inserting || (age_reg[i] < hit_age)))
                begin
                    age_next[i] = age_reg[i] + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.access && inserting)
        begin
            key_reg[slot] <= req.key;
        end
    end

    // A key is never held twice, so a lookup matches at most one entry.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(match))
        else $error("LRU table: key matches more than one entry");

    // The slot touched by an update is valid and most recent afterwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        do_update |=> valid_reg[$past(slot)] && (age_reg[$past(slot)] == '0))
        else $error("LRU table: updated slot is not valid and most recent");

    // A full table always has a unique oldest entry to evict.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.access && inserting && !any_free) |-> (age_reg[victim_idx] == OLDEST_AGE))
        else $error("LRU table: no oldest entry found in a full table");

endmodule

`default_nettype wire
